### src/rotate_point_about_axis_macros.svh
// Assertion macros for the rotate_point_about_axis checker.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ROTATE_POINT_ABOUT_AXIS_MACROS_SVH
`define ROTATE_POINT_ABOUT_AXIS_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RPA_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rotate_point_about_axis: check failed");

// Consequent checked in the cycle after the antecedent.
`define RPA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rotate_point_about_axis: check failed");

`endif

### src/rpa_pkg.sv
// Shared types, constants and the arctangent table for rotate_point_about_axis.
// No dependencies.
package rpa_pkg;

	localparam int CORDIC_STEPS = 18;
	localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	localparam int COORD_W = 32;
	localparam int ANGLE_W = 26;
	localparam int TRIG_W = 18;
	localparam int CFG_W = 26;
	localparam int RED_W = 27;
	localparam int CV_W = 34;
	localparam int ATAN_W = 23;
	localparam int PROD_W = COORD_W + TRIG_W;
	localparam int ACC_W = PROD_W + 1;

	localparam logic signed [RED_W-1:0] ANGLE_FULL = 27'sd23592960;
	localparam logic signed [RED_W-1:0] ANGLE_HALF = 27'sd11796480;
	localparam logic signed [RED_W-1:0] ANGLE_QUARTER = 27'sd5898240;
	localparam logic signed [CV_W-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [TRIG_W-1:0] COS_RESET = 18'sd65536;
	localparam logic signed [TRIG_W-1:0] SIN_RESET = 18'sd0;

	typedef enum logic [0:0] {
		REG_ANGLE = 1'b0,
		REG_AXIS = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2,
		AXIS_NONE = 2'd3
	} axis_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_REDUCE,
		CS_FOLD,
		CS_ITER,
		CS_ROUND
	} cordic_state_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] cosine;
		logic signed [TRIG_W-1:0] sine;
		logic busy;
	} trig_t;

	function automatic logic signed [ATAN_W-1:0] atan_deg(input logic [4:0] idx);
		logic signed [ATAN_W-1:0] v;
		case (idx)
			5'd0: v = 23'sd2949120;
			5'd1: v = 23'sd1740967;
			5'd2: v = 23'sd919879;
			5'd3: v = 23'sd466945;
			5'd4: v = 23'sd234379;
			5'd5: v = 23'sd117304;
			5'd6: v = 23'sd58666;
			5'd7: v = 23'sd29335;
			5'd8: v = 23'sd14668;
			5'd9: v = 23'sd7334;
			5'd10: v = 23'sd3667;
			5'd11: v = 23'sd1833;
			5'd12: v = 23'sd917;
			5'd13: v = 23'sd458;
			5'd14: v = 23'sd229;
			5'd15: v = 23'sd115;
			5'd16: v = 23'sd57;
			5'd17: v = 23'sd29;
			5'd18: v = 23'sd14;
			5'd19: v = 23'sd7;
			5'd20: v = 23'sd4;
			5'd21: v = 23'sd2;
			5'd22: v = 23'sd1;
			default: v = 23'sd0;
		endcase
		return v;
	endfunction

endpackage

### src/rpa_if.sv
// Valid/ready channel interfaces for input points and rotated results.
// Depends on rpa_pkg for the coordinate width.
interface rpa_in_if;
	logic valid;
	logic ready;
	logic signed [rpa_pkg::COORD_W-1:0] point_x;
	logic signed [rpa_pkg::COORD_W-1:0] point_y;
	logic signed [rpa_pkg::COORD_W-1:0] point_z;
	modport source (output valid, output point_x, output point_y, output point_z, input ready);
	modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface rpa_out_if;
	logic valid;
	logic ready;
	logic signed [rpa_pkg::COORD_W-1:0] rotated_x;
	logic signed [rpa_pkg::COORD_W-1:0] rotated_y;
	logic signed [rpa_pkg::COORD_W-1:0] rotated_z;
	modport source (output valid, output rotated_x, output rotated_y, output rotated_z,
		input ready);
	modport sink (input valid, input rotated_x, input rotated_y, input rotated_z,
		output ready);
endinterface

### src/rpa_cordic.sv
// Angle reduction and iterative CORDIC that produce the held cosine and sine.
// Depends on rpa_pkg.
module rpa_cordic (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [rpa_pkg::ANGLE_W-1:0] angle,
	output rpa_pkg::trig_t trig
);

	rpa_pkg::cordic_state_t state_q, state_d;
	logic signed [rpa_pkg::RED_W-1:0] ang_q, ang_d;
	logic signed [rpa_pkg::CV_W-1:0] x_q, x_d, y_q, y_d;
	logic [rpa_pkg::STEP_W-1:0] step_q, step_d;
	logic neg_q, neg_d;
	logic signed [rpa_pkg::TRIG_W-1:0] cos_q, cos_d, sin_q, sin_d;
	logic signed [rpa_pkg::RED_W-1:0] half_wrap;
	logic signed [rpa_pkg::RED_W-1:0] atan_ext;
	logic signed [rpa_pkg::CV_W-1:0] dx, dy, xr, yr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpa_pkg::CS_IDLE;
			cos_q <= rpa_pkg::COS_RESET;
			sin_q <= rpa_pkg::SIN_RESET;
		end else begin
			state_q <= state_d;
			cos_q <= cos_d;
			sin_q <= sin_d;
		end
	end

	always_ff @(posedge clk) begin
		ang_q <= ang_d;
		x_q <= x_d;
		y_q <= y_d;
		step_q <= step_d;
		neg_q <= neg_d;
	end

	always_comb begin
		state_d = state_q;
		ang_d = ang_q;
		x_d = x_q;
		y_d = y_q;
		step_d = step_q;
		neg_d = neg_q;
		cos_d = cos_q;
		sin_d = sin_q;
		half_wrap = (ang_q >= rpa_pkg::ANGLE_HALF) ? ang_q - rpa_pkg::ANGLE_FULL : ang_q;
		atan_ext = rpa_pkg::RED_W'(rpa_pkg::atan_deg(5'(step_q)));
		dx = y_q >>> step_q;
		dy = x_q >>> step_q;
		xr = (x_q + 34'sd8192) >>> 14;
		yr = (y_q + 34'sd8192) >>> 14;
		unique case (state_q)
			rpa_pkg::CS_IDLE: ;
			rpa_pkg::CS_REDUCE: begin
				if (ang_q < 0) begin
					ang_d = ang_q + rpa_pkg::ANGLE_FULL;
				end else if (ang_q >= rpa_pkg::ANGLE_FULL) begin
					ang_d = ang_q - rpa_pkg::ANGLE_FULL;
				end else begin
					state_d = rpa_pkg::CS_FOLD;
				end
			end
			rpa_pkg::CS_FOLD: begin
				neg_d = 1'b0;
				ang_d = half_wrap;
				if (half_wrap > rpa_pkg::ANGLE_QUARTER) begin
					ang_d = half_wrap - rpa_pkg::ANGLE_HALF;
					neg_d = 1'b1;
				end else if (half_wrap < -rpa_pkg::ANGLE_QUARTER) begin
					ang_d = half_wrap + rpa_pkg::ANGLE_HALF;
					neg_d = 1'b1;
				end
				x_d = rpa_pkg::CORDIC_GAIN;
				y_d = '0;
				step_d = '0;
				state_d = rpa_pkg::CS_ITER;
			end
			rpa_pkg::CS_ITER: begin
				if (ang_q >= 0) begin
					x_d = x_q - dx;
					y_d = y_q + dy;
					ang_d = ang_q - atan_ext;
				end else begin
					x_d = x_q + dx;
					y_d = y_q - dy;
					ang_d = ang_q + atan_ext;
				end
				if (step_q == rpa_pkg::STEP_W'(rpa_pkg::CORDIC_STEPS - 1)) begin
					state_d = rpa_pkg::CS_ROUND;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			rpa_pkg::CS_ROUND: begin
				cos_d = neg_q ? -xr[rpa_pkg::TRIG_W-1:0] : xr[rpa_pkg::TRIG_W-1:0];
				sin_d = neg_q ? -yr[rpa_pkg::TRIG_W-1:0] : yr[rpa_pkg::TRIG_W-1:0];
				state_d = rpa_pkg::CS_IDLE;
			end
			default: state_d = rpa_pkg::CS_IDLE;
		endcase
		// A new angle always restarts the computation, even while one is running.
		if (start) begin
			ang_d = rpa_pkg::RED_W'(angle);
			state_d = rpa_pkg::CS_REDUCE;
		end
	end

	assign trig.cosine = cos_q;
	assign trig.sine = sin_q;
	assign trig.busy = (state_q != rpa_pkg::CS_IDLE);

endmodule

### src/rpa_datapath.sv
// Two-register point path: input register, then the rounded and saturated result register.
// Depends on rpa_pkg and the channel interfaces in rpa_if.sv.
module rpa_datapath (
	input  logic clk,
	input  logic arst_n,
	input  rpa_pkg::trig_t trig,
	input  rpa_pkg::axis_t axis,
	rpa_in_if.sink points,
	rpa_out_if.source results
);

	localparam int W = rpa_pkg::COORD_W;
	localparam int RW = rpa_pkg::ACC_W - 16;

	logic advance;
	logic v_s1, out_valid_q;
	logic signed [W-1:0] x_s1, y_s1, z_s1;
	rpa_pkg::axis_t axis_s1;
	logic signed [W-1:0] u, v;
	logic signed [rpa_pkg::PROD_W-1:0] uc, vs, us, vc;
	logic signed [rpa_pkg::ACC_W-1:0] acc_u, acc_v;
	logic signed [W-1:0] ru, rv;
	logic signed [W-1:0] ox_q, oy_q, oz_q, ox_d, oy_d, oz_d;

	function automatic logic signed [W-1:0] finish(input logic signed [rpa_pkg::ACC_W-1:0] a);
		logic signed [RW-1:0] r;
		r = RW'((a + rpa_pkg::ACC_W'(32768)) >>> 16);
		if (r > RW'(2147483647)) begin
			return 32'sh7FFFFFFF;
		end else if (r < -RW'(64'sd2147483648)) begin
			return 32'sh80000000;
		end
		return r[W-1:0];
	endfunction

	assign advance = !out_valid_q || results.ready;
	assign points.ready = advance && !trig.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1 <= points.valid && !trig.busy;
			out_valid_q <= v_s1;
		end
	end

	always_comb begin
		unique case (axis_s1)
			rpa_pkg::AXIS_X: begin
				u = y_s1;
				v = z_s1;
			end
			rpa_pkg::AXIS_Y: begin
				u = z_s1;
				v = x_s1;
			end
			default: begin
				u = x_s1;
				v = y_s1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_s1 <= points.point_x;
			y_s1 <= points.point_y;
			z_s1 <= points.point_z;
			axis_s1 <= axis;
			ox_q <= ox_d;
			oy_q <= oy_d;
			oz_q <= oz_d;
		end
	end

	always_comb begin
		uc = u * $signed(trig.cosine);
		vs = v * $signed(trig.sine);
		us = u * $signed(trig.sine);
		vc = v * $signed(trig.cosine);
		acc_u = rpa_pkg::ACC_W'(uc) - rpa_pkg::ACC_W'(vs);
		acc_v = rpa_pkg::ACC_W'(us) + rpa_pkg::ACC_W'(vc);
		ru = finish(acc_u);
		rv = finish(acc_v);
		ox_d = x_s1;
		oy_d = y_s1;
		oz_d = z_s1;
		unique case (axis_s1)
			rpa_pkg::AXIS_Z: begin
				ox_d = ru;
				oy_d = rv;
			end
			rpa_pkg::AXIS_X: begin
				oy_d = ru;
				oz_d = rv;
			end
			rpa_pkg::AXIS_Y: begin
				oz_d = ru;
				ox_d = rv;
			end
			default: begin
			end
		endcase
	end

	assign results.valid = out_valid_q;
	assign results.rotated_x = ox_q;
	assign results.rotated_y = oy_q;
	assign results.rotated_z = oz_q;

endmodule

### src/rotate_point_about_axis.sv
// Top level of rotate_point_about_axis: configuration registers, CORDIC and point pipeline.
// Depends on rpa_pkg, rpa_if.sv, rpa_cordic and rpa_datapath.
//
// Rotates a Q16.16 point about the X, Y or Z axis by the configured angle (AXIS_NONE
// passes it unchanged). Points are accepted one per cycle, unless the path is stalled or
// the CORDIC is busy, into an input register; the rotated, rounded and saturated item is
// then registered into the result register, from which it is offered. A result that is
// not taken holds the whole path and drops the input ready. Writing the angle register
// starts a CORDIC that does one micro-rotation per cycle; points are held off after the
// write while the angle is reduced, folded, iterated and rounded.
module rotate_point_about_axis (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [rpa_pkg::CFG_W-1:0] cfg_data,
	rpa_in_if.sink points,
	rpa_out_if.source results
);

	rpa_pkg::axis_t axis_q;
	rpa_pkg::trig_t trig;
	logic angle_start;

	assign angle_start = cfg_we && (cfg_index == rpa_pkg::REG_ANGLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= rpa_pkg::AXIS_Z;
		end else if (cfg_we && (cfg_index == rpa_pkg::REG_AXIS)) begin
			axis_q <= rpa_pkg::axis_t'(cfg_data[1:0]);
		end
	end

	rpa_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(angle_start),
		.angle(signed'(cfg_data[rpa_pkg::ANGLE_W-1:0])),
		.trig(trig)
	);

	rpa_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.trig(trig),
		.axis(axis_q),
		.points(points),
		.results(results)
	);

endmodule

### src/rpa_checker.sv
// Port-level checks for rotate_point_about_axis, attached by bind.
// Depends on rotate_point_about_axis_macros.svh.
`include "rotate_point_about_axis_macros.svh"

module rpa_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [95:0] out_data
);

	`RPA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`RPA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))
	`RPA_ASSERT_NEXT(a_angle_blocks, cfg_we && (cfg_index == rpa_pkg::REG_ANGLE), !in_ready)
	`RPA_ASSERT_SAME(a_stall_blocks, out_valid && !out_ready, !in_ready)

endmodule

bind rotate_point_about_axis rpa_checker u_rpa_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cfg_we(cfg_we),
	.cfg_index(cfg_index),
	.in_ready(points.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_data({results.rotated_x, results.rotated_y, results.rotated_z})
);

### verif/tb_rotate_point_about_axis.sv
// Testbench for rotate_point_about_axis: directed and random points under several angles and axes.
// Results are checked against an in-bench fixed-point rotation with its own CORDIC.
// Depends on rpa_pkg, rpa_if.sv and the rotate_point_about_axis RTL.
module tb_rotate_point_about_axis;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint TURN = 23592960;
	localparam longint HALF_TURN = 11796480;
	localparam longint QUARTER_TURN = 5898240;
	localparam longint START_GAIN = 652032874;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE = 12;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = rpa_pkg::REG_ANGLE;
	logic [rpa_pkg::CFG_W-1:0] cfg_data = '0;

	rpa_in_if points ();
	rpa_out_if results ();

	rotate_point_about_axis dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.points(points.sink),
		.results(results.source)
	);

	longint arctan_deg[32] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
		29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1,
		0, 0, 0, 0, 0, 0, 0, 0, 0};

	longint cos_q16 = 65536;
	longint sin_q16 = 0;
	rpa_pkg::axis_t axis_sel = rpa_pkg::AXIS_Z;

	point_t pending_points[$];
	point_t expected_rotations[$];
	int mismatches = 0;
	int stall_cycles = 0;
	int in_gap = 0;
	int out_gap = 0;
	bit calm = 1'b0;
	logic in_taken = 1'b0;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic void load_trig(input logic [rpa_pkg::ANGLE_W-1:0] raw);
		longint r, x, y, z, dx, dy;
		bit flip;
		int steps;
		flip = 1'b0;
		steps = (rpa_pkg::CORDIC_STEPS > 32) ? 32 : rpa_pkg::CORDIC_STEPS;
		r = longint'($signed(raw)) % TURN;
		if (r < 0)
			r += TURN;
		if (r >= HALF_TURN)
			r -= TURN;
		if (r > QUARTER_TURN) begin
			r -= HALF_TURN;
			flip = 1'b1;
		end else if (r < -QUARTER_TURN) begin
			r += HALF_TURN;
			flip = 1'b1;
		end
		x = START_GAIN;
		y = 0;
		z = r;
		for (int i = 0; i < steps; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= arctan_deg[i];
			end else begin
				x += dx;
				y -= dy;
				z += arctan_deg[i];
			end
		end
		x = (x + 8192) >>> 14;
		y = (y + 8192) >>> 14;
		cos_q16 = flip ? -x : x;
		sin_q16 = flip ? -y : y;
	endfunction

	function automatic logic signed [31:0] round_sat(input longint acc);
		longint r;
		r = (acc + 32768) >>> 16;
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return r[31:0];
	endfunction

	function automatic point_t rotate(input point_t p);
		point_t q;
		longint x, y, z;
		q = p;
		x = p.x;
		y = p.y;
		z = p.z;
		case (axis_sel)
			rpa_pkg::AXIS_Z: begin
				q.x = round_sat(x * cos_q16 - y * sin_q16);
				q.y = round_sat(x * sin_q16 + y * cos_q16);
			end
			rpa_pkg::AXIS_Y: begin
				q.x = round_sat(x * cos_q16 + z * sin_q16);
				q.z = round_sat(z * cos_q16 - x * sin_q16);
			end
			rpa_pkg::AXIS_X: begin
				q.y = round_sat(y * cos_q16 - z * sin_q16);
				q.z = round_sat(y * sin_q16 + z * cos_q16);
			end
			default: ;
		endcase
		return q;
	endfunction

	task automatic write_reg(input rpa_pkg::reg_index_t idx,
		input logic [rpa_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == rpa_pkg::REG_ANGLE)
			load_trig(value[rpa_pkg::ANGLE_W-1:0]);
		else
			axis_sel = rpa_pkg::axis_t'(value[1:0]);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] any_coord();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			1, 2: return $urandom;
			default: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
		endcase
	endfunction

	task automatic queue_points(input int count);
		point_t p;
		for (int i = 0; i < count; i++) begin
			p.x = any_coord();
			p.y = any_coord();
			p.z = any_coord();
			pending_points.insert(pending_points.size(), p);
		end
	endtask

	task automatic queue_corners();
		logic [31:0] edges[6] = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF,
			32'h00010000, 32'hFFFF0000};
		point_t p;
		for (int i = 0; i < 6; i++) begin
			p.x = edges[i];
			p.y = edges[(i + 1) % 6];
			p.z = edges[(i + 3) % 6];
			pending_points.insert(pending_points.size(), p);
		end
	endtask

	task automatic drain();
		while (pending_points.size() != 0 || points.valid || expected_rotations.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic run_phase(input logic [rpa_pkg::CFG_W-1:0] angle, input rpa_pkg::axis_t ax,
		input int count);
		write_reg(rpa_pkg::REG_ANGLE, angle);
		write_reg(rpa_pkg::REG_AXIS,
			rpa_pkg::CFG_W'({$urandom} << 2) | rpa_pkg::CFG_W'(ax));
		queue_corners();
		queue_points(count);
		drain();
	endtask

	always @(negedge clk) begin
		if (!points.valid || in_taken) begin
			if (in_gap > 0) begin
				in_gap--;
				points.valid <= 1'b0;
			end else if (pending_points.size() != 0 && !calm && $urandom_range(0, 11) == 0) begin
				in_gap = $urandom_range(1, 18) - 1;
				points.valid <= 1'b0;
			end else if (pending_points.size() != 0) begin
				point_t p;
				p = pending_points.pop_front();
				points.point_x <= p.x;
				points.point_y <= p.y;
				points.point_z <= p.z;
				points.valid <= 1'b1;
			end else begin
				points.valid <= 1'b0;
			end
		end
		if (out_gap > 0) begin
			out_gap--;
			results.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			out_gap = $urandom_range(1, 18) - 1;
			results.ready <= 1'b0;
		end else begin
			results.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		point_t got, want, p;
		in_taken <= points.valid && points.ready;
		if (points.valid && points.ready) begin
			p.x = points.point_x;
			p.y = points.point_y;
			p.z = points.point_z;
			expected_rotations.insert(expected_rotations.size(), rotate(p));
		end
		if (results.valid && results.ready) begin
			got.x = results.rotated_x;
			got.y = results.rotated_y;
			got.z = results.rotated_z;
			if (expected_rotations.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h %h %h", got.x, got.y, got.z);
			end else begin
				want = expected_rotations.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h %h %h, got %h %h %h",
							want.x, want.y, want.z, got.x, got.y, got.z);
				end
			end
		end
		if ((points.valid && points.ready) || (results.valid && results.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_rotate_point_about_axis: FAIL");
			$finish;
		end
	end

	initial begin
		points.valid = 1'b0;
		points.point_x = '0;
		points.point_y = '0;
		points.point_z = '0;
		results.ready = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// The reset trig values are exact, so the first points see an ideal unit rotation.
		queue_corners();
		queue_points(20);
		drain();

		run_phase(rpa_pkg::CFG_W'(0), rpa_pkg::AXIS_X, 40);
		run_phase(rpa_pkg::CFG_W'(5898240), rpa_pkg::AXIS_Y, 40);
		run_phase(rpa_pkg::CFG_W'(-5898240), rpa_pkg::AXIS_Z, 40);
		run_phase(rpa_pkg::CFG_W'(11796480), rpa_pkg::AXIS_Z, 40);
		run_phase(rpa_pkg::CFG_W'(-11796480), rpa_pkg::AXIS_X, 40);
		run_phase(rpa_pkg::CFG_W'(23592960), rpa_pkg::AXIS_Y, 40);
		run_phase(rpa_pkg::CFG_W'(-23592960), rpa_pkg::AXIS_Z, 40);
		run_phase(rpa_pkg::CFG_W'(2949120), rpa_pkg::AXIS_NONE, 40);
		run_phase(26'h1FFFFFF, rpa_pkg::AXIS_X, 40);
		run_phase(26'h2000000, rpa_pkg::AXIS_Y, 40);
		run_phase(rpa_pkg::CFG_W'(5898241), rpa_pkg::AXIS_Z, 40);
		for (int k = 0; k < 4; k++)
			run_phase(rpa_pkg::CFG_W'($urandom), rpa_pkg::axis_t'($urandom_range(0, 3)), 50);
		calm = 1'b1;
		run_phase(rpa_pkg::CFG_W'($signed($urandom_range(0, 47185920)) - 23592960),
			rpa_pkg::AXIS_Z, 60);

		if (mismatches == 0 && expected_rotations.size() == 0)
			$display("tb_rotate_point_about_axis: PASS");
		else
			$display("tb_rotate_point_about_axis: FAIL");
		$finish;
	end
endmodule
